[rtl/core/se3_pkg.sv]
// ----------------------------------------------------------------------------
// se3_pkg
// Shared types, constants and helpers for the twist exponential series block.
// ----------------------------------------------------------------------------
package se3_pkg;

    // data word width of every matrix entry
    localparam int Q_W = 32;
    // term counter width, covers the largest term limit
    localparam int CNT_W = 6;
    // configuration register width
    localparam int TC_W = 5;

    localparam int DEF_MAX_TERMS = 20;
    localparam int DEF_FRAC_BITS = 24;

    localparam logic [TC_W-1:0] TERM_COUNT_RESET = 5'd10;

    // register byte addresses
    localparam logic [2:0] ADDR_TERM_COUNT = 3'd0;

    // one item in flight along the cell row
    typedef struct packed {
        logic                   valid;
        logic [CNT_W-1:0]       cnt;
        logic [8:0][Q_W-1:0]    s;
        logic [2:0][Q_W-1:0]    rho;
        logic [8:0][Q_W-1:0]    r;
        logic [8:0][Q_W-1:0]    acc_r;
        logic [2:0][Q_W-1:0]    acc_t;
    } item_t;

    // clamp a wide signed value to the signed 32-bit range
    function automatic logic signed [Q_W-1:0] sat32(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = 64'sd2147483647;
        lo = -64'sd2147483648;
        if (v > hi)
            sat32 = 32'sh7fffffff;
        else if (v < lo)
            sat32 = 32'sh80000000;
        else
            sat32 = v[Q_W-1:0];
    endfunction

endpackage

[rtl/core/se3_cell.sv]
// ----------------------------------------------------------------------------
// se3_cell
// One series term: next term = prev * [S | rho] * recip(N), accumulated.
// Three register stages: products, row sums times recip, round and add.
// ----------------------------------------------------------------------------
module se3_cell #(
    parameter int N         = 1,
    parameter int FRAC_BITS = se3_pkg::DEF_FRAC_BITS
) (
    input  logic           clk,
    input  logic           rst_n,
    input  se3_pkg::item_t item_in,
    output se3_pkg::item_t item_out
);

    localparam int QW = se3_pkg::Q_W;
    localparam int RW = 2 * QW - FRAC_BITS;
    localparam int SW = RW + 2;
    localparam int KW = FRAC_BITS + 2;
    localparam int MW = QW + KW;
    localparam int HW = MW - FRAC_BITS;
    localparam int IW = $bits(se3_pkg::item_t);
    localparam logic [FRAC_BITS:0] RECIP = (FRAC_BITS+1)'(((1 << FRAC_BITS) + N / 2) / N);

    se3_pkg::item_t item1_reg, item2_reg, item3_reg;
    logic                 valid1_reg, valid2_reg, valid3_reg;
    logic signed [RW-1:0] prod_next [36];
    logic signed [RW-1:0] prod_reg  [36];
    logic signed [MW-1:0] mul_next  [12];
    logic signed [MW-1:0] mul_reg   [12];
    logic [8:0][QW-1:0]   r_next;
    logic [8:0][QW-1:0]   accr_next;
    logic [2:0][QW-1:0]   acct_next;
    logic                 active;

    function automatic logic signed [RW-1:0] rnd_prod(input logic signed [QW-1:0] a,
                                                      input logic signed [QW-1:0] b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b);
        p = p + (64'sd1 <<< (FRAC_BITS - 1));
        rnd_prod = RW'(p >>> FRAC_BITS);
    endfunction

    // stage 1 products: entries 0..26 rotation (i,j,k), 27..35 translation (i,k)
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    prod_next[i*9 + j*3 + k] = rnd_prod($signed(item_in.r[i*3 + k]),
                                                        $signed(item_in.s[k*3 + j]));
                end
            end
            for (int k = 0; k < 3; k++)
            begin
                prod_next[27 + i*3 + k] = rnd_prod($signed(item_in.r[i*3 + k]),
                                                   $signed(item_in.rho[k]));
            end
        end
    end

    // stage 2 row sums, saturate, scale by reciprocal
    always_comb
    begin
        logic signed [SW-1:0] sum;
        logic signed [QW-1:0] v;
        for (int e = 0; e < 12; e++)
        begin
            sum = SW'(prod_reg[e*3]) + SW'(prod_reg[e*3 + 1]) + SW'(prod_reg[e*3 + 2]);
            v   = se3_pkg::sat32(64'(sum));
            mul_next[e] = MW'(v) * MW'($signed({1'b0, RECIP}));
        end
    end

    // stage 3 round, saturate and accumulate when this term is in range
    assign active = (item2_reg.cnt >= se3_pkg::CNT_W'(N));

    always_comb
    begin
        logic signed [63:0] t;
        logic signed [QW-1:0] nv;
        r_next    = item2_reg.r;
        accr_next = item2_reg.acc_r;
        acct_next = item2_reg.acc_t;
        for (int e = 0; e < 12; e++)
        begin
            t  = 64'(mul_reg[e]) + (64'sd1 <<< (FRAC_BITS - 1));
            t  = 64'(HW'(t >>> FRAC_BITS));
            nv = se3_pkg::sat32(t);
            if (active)
            begin
                if (e < 9)
                begin
                    r_next[e]    = nv;
                    accr_next[e] = se3_pkg::sat32(64'($signed(item2_reg.acc_r[e])) + 64'(nv));
                end
                else
                begin
                    acct_next[e-9] = se3_pkg::sat32(64'($signed(item2_reg.acc_t[e-9]))
                                                    + 64'(nv));
                end
            end
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
            valid3_reg <= 1'b0;
        end
        else
        begin
            valid1_reg <= item_in.valid;
            valid2_reg <= valid1_reg;
            valid3_reg <= valid2_reg;
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        item1_reg.valid <= item_in.valid;
        item1_reg.cnt   <= item_in.cnt;
        item1_reg.s     <= item_in.s;
        item1_reg.rho   <= item_in.rho;
        item1_reg.r     <= item_in.r;
        item1_reg.acc_r <= item_in.acc_r;
        item1_reg.acc_t <= item_in.acc_t;
        prod_reg        <= prod_next;

        item2_reg.valid <= item1_reg.valid;
        item2_reg.cnt   <= item1_reg.cnt;
        item2_reg.s     <= item1_reg.s;
        item2_reg.rho   <= item1_reg.rho;
        item2_reg.r     <= item1_reg.r;
        item2_reg.acc_r <= item1_reg.acc_r;
        item2_reg.acc_t <= item1_reg.acc_t;
        mul_reg         <= mul_next;

        item3_reg.valid <= item2_reg.valid;
        item3_reg.cnt   <= item2_reg.cnt;
        item3_reg.s     <= item2_reg.s;
        item3_reg.rho   <= item2_reg.rho;
        item3_reg.r     <= r_next;
        item3_reg.acc_r <= accr_next;
        item3_reg.acc_t <= acct_next;
    end

    // valid bit in front of the payload
    assign item_out = {valid3_reg, item3_reg[IW-2:0]};

endmodule

[rtl/core/se3_exp_series.sv]
// ----------------------------------------------------------------------------
// se3_exp_series
// Twist to rigid transform by a truncated Taylor series, one cell per term.
//
//   channel   handshake             payload
//   input     start / busy          twist_rho_*, twist_phi_*
//   result    done (one cycle)      rot_00..rot_22, trans_x..trans_z
//   config    apb psel/penable      term_count at byte address 0
//
// one beat may enter every cycle; busy stays low
// the path is one entry stage, then three stages per cell
// terms past term_count pass through their cell unchanged
// reset clears the valid bits and restores term_count to 10
// the receiver cannot stall; each result is shown for one cycle
// ----------------------------------------------------------------------------
module se3_exp_series #(
    parameter int MAX_TERMS = se3_pkg::DEF_MAX_TERMS,
    parameter int FRAC_BITS = se3_pkg::DEF_FRAC_BITS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] twist_rho_x,
    input  logic signed [31:0] twist_rho_y,
    input  logic signed [31:0] twist_rho_z,
    input  logic signed [31:0] twist_phi_x,
    input  logic signed [31:0] twist_phi_y,
    input  logic signed [31:0] twist_phi_z,
    output logic               done,
    output logic signed [31:0] rot_00,
    output logic signed [31:0] rot_01,
    output logic signed [31:0] rot_02,
    output logic signed [31:0] rot_10,
    output logic signed [31:0] rot_11,
    output logic signed [31:0] rot_12,
    output logic signed [31:0] rot_20,
    output logic signed [31:0] rot_21,
    output logic signed [31:0] rot_22,
    output logic signed [31:0] trans_x,
    output logic signed [31:0] trans_y,
    output logic signed [31:0] trans_z
);

    localparam int QW = se3_pkg::Q_W;
    localparam int CW = se3_pkg::CNT_W;
    localparam int IW = $bits(se3_pkg::item_t);
    localparam int LATENCY = 1 + 3 * MAX_TERMS;
    localparam logic [QW-1:0] ONE = QW'(1) << FRAC_BITS;

    logic [se3_pkg::TC_W-1:0] term_count_reg;
    logic                     cfg_wr;
    logic [CW-1:0]            cnt_eff;
    logic                     entry_valid_reg;
    se3_pkg::item_t           entry_reg;
    se3_pkg::item_t           chain [MAX_TERMS+1];

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            term_count_reg <= se3_pkg::TERM_COUNT_RESET;
        else if (cfg_wr && paddr == se3_pkg::ADDR_TERM_COUNT)
            term_count_reg <= pwdata[se3_pkg::TC_W-1:0];
    end

    always_comb
    begin
        prdata = '0;
        if (paddr == se3_pkg::ADDR_TERM_COUNT)
            prdata = 32'(term_count_reg);
    end

    // term count clamp
    assign cnt_eff = (CW'(term_count_reg) > CW'(MAX_TERMS)) ? CW'(MAX_TERMS)
                                                             : CW'(term_count_reg);

    assign busy = 1'b0;

    // entry stage: valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            entry_valid_reg <= 1'b0;
        else
            entry_valid_reg <= start;
    end

    // entry stage: skew matrix, identity start
    always_ff @(posedge clk)
    begin
        entry_reg.valid  <= start;
        entry_reg.cnt    <= cnt_eff;
        entry_reg.s[0]   <= '0;
        entry_reg.s[1]   <= se3_pkg::sat32(-64'(twist_phi_z));
        entry_reg.s[2]   <= twist_phi_y;
        entry_reg.s[3]   <= twist_phi_z;
        entry_reg.s[4]   <= '0;
        entry_reg.s[5]   <= se3_pkg::sat32(-64'(twist_phi_x));
        entry_reg.s[6]   <= se3_pkg::sat32(-64'(twist_phi_y));
        entry_reg.s[7]   <= twist_phi_x;
        entry_reg.s[8]   <= '0;
        entry_reg.rho[0] <= twist_rho_x;
        entry_reg.rho[1] <= twist_rho_y;
        entry_reg.rho[2] <= twist_rho_z;
        for (int e = 0; e < 9; e++)
        begin
            entry_reg.r[e]     <= (e % 4 == 0) ? ONE : '0;
            entry_reg.acc_r[e] <= (e % 4 == 0) ? ONE : '0;
        end
        entry_reg.acc_t <= '0;
    end

    assign chain[0] = {entry_valid_reg, entry_reg[IW-2:0]};

    // row of term cells
    for (genvar g = 0; g < MAX_TERMS; g++)
    begin : g_cell
        se3_cell #(
            .N         (g + 1),
            .FRAC_BITS (FRAC_BITS)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .item_in  (chain[g]),
            .item_out (chain[g+1])
        );
    end

    // result beat
    assign done    = chain[MAX_TERMS].valid;
    assign rot_00  = chain[MAX_TERMS].acc_r[0];
    assign rot_01  = chain[MAX_TERMS].acc_r[1];
    assign rot_02  = chain[MAX_TERMS].acc_r[2];
    assign rot_10  = chain[MAX_TERMS].acc_r[3];
    assign rot_11  = chain[MAX_TERMS].acc_r[4];
    assign rot_12  = chain[MAX_TERMS].acc_r[5];
    assign rot_20  = chain[MAX_TERMS].acc_r[6];
    assign rot_21  = chain[MAX_TERMS].acc_r[7];
    assign rot_22  = chain[MAX_TERMS].acc_r[8];
    assign trans_x = chain[MAX_TERMS].acc_t[0];
    assign trans_y = chain[MAX_TERMS].acc_t[1];
    assign trans_z = chain[MAX_TERMS].acc_t[2];

    // checks
    a_done_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LATENCY))
        else $error("result beat without matching input beat");

    a_start_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("input beat lost in cell row");

    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_wr && paddr == se3_pkg::ADDR_TERM_COUNT)
            |=> term_count_reg == $past(pwdata[se3_pkg::TC_W-1:0]))
        else $error("term_count write not taken");

    a_cnt_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        entry_valid_reg |-> entry_reg.cnt <= CW'(MAX_TERMS))
        else $error("term count not clamped");

endmodule

[verif/se3_exp_series_tb.sv]
// ----------------------------------------------------------------------------
// se3_exp_series_tb
// Self-checking bench for the twist exponential series block: a directed
// table of twists, then random twists under several term_count settings;
// each checked against a typed-in pose or a fixed-point series predictor.
// ----------------------------------------------------------------------------
module se3_exp_series_tb;

    localparam int FRAC   = 24;
    localparam int NTERMS = 20;
    localparam int LAT    = 1 + 3 * NTERMS;
    localparam int WDOG   = 4000;
    localparam logic signed [31:0] ONE  = 32'sh01000000;
    localparam logic signed [31:0] QMAX = 32'sh7fffffff;
    localparam logic signed [31:0] QMIN = 32'sh80000000;

    typedef logic signed [31:0] q_t;
    typedef struct {
        q_t v [12];
    } pose_t;
    typedef struct {
        q_t    tw [6];
        logic  has_exp;
        pose_t exp_pose;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic start = 1'b0;
    logic busy;
    q_t rho_x = '0, rho_y = '0, rho_z = '0, phi_x = '0, phi_y = '0, phi_z = '0;
    logic done;
    q_t r00, r01, r02, r10, r11, r12, r20, r21, r22, tx, ty, tz;

    pose_t pose_q [$];
    int    errors = 0;
    int    idle_cycles = 0;
    logic [4:0] cur_terms = 5'd10;
    logic  no_gaps = 1'b0;

    se3_exp_series dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .start(start), .busy(busy),
        .twist_rho_x(rho_x), .twist_rho_y(rho_y), .twist_rho_z(rho_z),
        .twist_phi_x(phi_x), .twist_phi_y(phi_y), .twist_phi_z(phi_z),
        .done(done),
        .rot_00(r00), .rot_01(r01), .rot_02(r02),
        .rot_10(r10), .rot_11(r11), .rot_12(r12),
        .rot_20(r20), .rot_21(r21), .rot_22(r22),
        .trans_x(tx), .trans_y(ty), .trans_z(tz)
    );

    always #10 clk = ~clk;

    // fixed-point helpers
    function automatic q_t clamp(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return QMAX;
        if (v < -64'sd2147483648)
            return QMIN;
        return v[31:0];
    endfunction

    // round to nearest, ties up; arithmetic shift is a floor
    function automatic logic signed [63:0] rnd_mul(input q_t a, input logic signed [63:0] b);
        logic signed [63:0] p;
        p = 64'(a) * b + (64'sd1 <<< (FRAC - 1));
        return p >>> FRAC;
    endfunction

    function automatic q_t scale_by_inv(input q_t v, input int n);
        logic signed [63:0] rc;
        rc = ((64'sd1 <<< FRAC) + n / 2) / n;
        return clamp(rnd_mul(v, rc));
    endfunction

    // series sum of the twist exponential
    function automatic pose_t exp_series(input q_t tw [6], input logic [4:0] terms);
        q_t s [3][3];
        q_t r [3][3];
        q_t nr [3][3];
        q_t nt [3];
        q_t acc [3][3];
        q_t at [3];
        logic signed [63:0] sum;
        int cnt;
        pose_t p;
        s[0][0] = 0;                   s[0][1] = clamp(-64'(tw[5])); s[0][2] = tw[4];
        s[1][0] = tw[5];               s[1][1] = 0;                  s[1][2] = clamp(-64'(tw[3]));
        s[2][0] = clamp(-64'(tw[4])); s[2][1] = tw[3];              s[2][2] = 0;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                r[i][j] = (i == j) ? ONE : 0;
                acc[i][j] = r[i][j];
            end
            at[i] = 0;
        end
        cnt = (terms > NTERMS) ? NTERMS : terms;
        for (int n = 1; n <= cnt; n++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    sum = 0;
                    for (int k = 0; k < 3; k++)
                        sum += rnd_mul(r[i][k], 64'(s[k][j]));
                    nr[i][j] = scale_by_inv(clamp(sum), n);
                end
                sum = 0;
                for (int k = 0; k < 3; k++)
                    sum += rnd_mul(r[i][k], 64'(tw[k]));
                nt[i] = scale_by_inv(clamp(sum), n);
            end
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    r[i][j] = nr[i][j];
                    acc[i][j] = clamp(64'(acc[i][j]) + 64'(nr[i][j]));
                end
                at[i] = clamp(64'(at[i]) + 64'(nt[i]));
            end
        end
        for (int i = 0; i < 9; i++)
            p.v[i] = acc[i / 3][i % 3];
        for (int i = 0; i < 3; i++)
            p.v[9 + i] = at[i];
        return p;
    endfunction

    // result checker and idle watchdog
    always @(posedge clk)
    begin
        pose_t got;
        pose_t want;
        logic bad;
        if (rst_n)
        begin
            if ((start && !busy) || done)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (done)
            begin
                got.v = '{r00, r01, r02, r10, r11, r12, r20, r21, r22, tx, ty, tz};
                if (pose_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result beat");
                end
                else
                begin
                    want = pose_q.pop_front();
                    bad = 1'b0;
                    for (int i = 0; i < 12; i++)
                        if (got.v[i] !== want.v[i])
                        begin
                            bad = 1'b1;
                            if (errors < 10)
                                $display("field %0d: expected %h got %h",
                                         i, want.v[i], got.v[i]);
                        end
                    if (bad)
                        errors++;
                end
            end
            if (idle_cycles >= WDOG)
            begin
                $display("se3_exp_series verification failed");
                $finish;
            end
        end
    end

    task automatic wait_cycles(input int n);
        repeat (n) @(negedge clk);
    endtask

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
        psel = 1'b1; pwrite = 1'b1; paddr = addr; pwdata = data;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        if (addr == se3_pkg::ADDR_TERM_COUNT)
            cur_terms = data[4:0];
    endtask

    // wait for the pipe to drain before touching the register
    task automatic drain();
        while (pose_q.size() != 0)
            @(negedge clk);
        wait_cycles(LAT + 4);
    endtask

    task automatic send_twist(input q_t tw [6], input logic use_exp, input pose_t exp_p);
        if (!no_gaps && $urandom_range(0, 3) == 0)
        begin
            start = 1'b0;
            wait_cycles($urandom_range(1, 12));
        end
        rho_x = tw[0]; rho_y = tw[1]; rho_z = tw[2];
        phi_x = tw[3]; phi_y = tw[4]; phi_z = tw[5];
        start = 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pose_q.push_back(use_exp ? exp_p : exp_series(tw, cur_terms));
        @(negedge clk);
    endtask

    function automatic q_t rand_q(input int mode);
        case (mode)
            0: return $urandom();
            1: return q_t'($urandom_range(0, 32'h00ffffff)) - 32'sh00800000;
            2: return q_t'($urandom_range(0, 32'h07ffffff)) - 32'sh04000000;
            default: return $urandom_range(0, 1) ? QMAX : QMIN;
        endcase
    endfunction

    // directed twists; expected pose typed in for the trivial rows
    function automatic pose_t ident_pose(input q_t tx0, input q_t ty0, input q_t tz0);
        pose_t p;
        p.v = '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE, tx0, ty0, tz0};
        return p;
    endfunction

    initial
    begin
        row_t dir [$];
        row_t rw;
        pose_t none;
        q_t tw [6];
        logic [4:0] settings [6] = '{5'd1, 5'd20, 5'd31, 5'd0, 5'd3, 5'd10};
        none = ident_pose(0, 0, 0);

        wait_cycles(6);
        rst_n = 1'b1;
        wait_cycles(2);

        // zero twist gives identity; pure translation gives identity plus rho
        rw.tw = '{0, 0, 0, 0, 0, 0};   rw.has_exp = 1; rw.exp_pose = none; dir.push_back(rw);
        rw.tw = '{ONE, -ONE, 32'sh00400000, 0, 0, 0};
        rw.exp_pose = ident_pose(ONE, -ONE, 32'sh00400000); dir.push_back(rw);
        rw.has_exp = 0;
        rw.tw = '{QMAX, QMAX, QMAX, QMAX, QMAX, QMAX}; dir.push_back(rw);
        rw.tw = '{QMIN, QMIN, QMIN, QMIN, QMIN, QMIN}; dir.push_back(rw);
        rw.tw = '{0, 0, 0, QMIN, 0, 0}; dir.push_back(rw);
        rw.tw = '{0, 0, 0, 0, QMIN, 0}; dir.push_back(rw);
        rw.tw = '{0, 0, 0, 0, 0, QMIN}; dir.push_back(rw);
        rw.tw = '{ONE, ONE, ONE, 32'sh01921fb5, 0, 0}; dir.push_back(rw);
        rw.tw = '{0, ONE, 0, 0, 32'sh00800000, 32'shff800000}; dir.push_back(rw);
        rw.tw = '{-1, 1, -1, 1, -1, 1}; dir.push_back(rw);
        rw.tw = '{QMAX, QMIN, 0, ONE, -ONE, ONE}; dir.push_back(rw);
        rw.tw = '{32'sh55555555, 32'shaaaaaaaa, 32'sh0f0f0f0f,
                  32'sh00c00000, 32'shff400000, 32'sh00200000}; dir.push_back(rw);

        // reset value of term_count applies to the first pass
        foreach (dir[i])
            send_twist(dir[i].tw, dir[i].has_exp, dir[i].exp_pose);
        start = 1'b0;

        // term count zero leaves the identity whatever the twist
        drain();
        reg_write(se3_pkg::ADDR_TERM_COUNT, 32'd0);
        tw = '{QMAX, 5, 7, ONE, QMIN, 3};
        send_twist(tw, 1, none);
        start = 1'b0;

        // random part, several settings including both extremes
        foreach (settings[s])
        begin
            drain();
            reg_write(se3_pkg::ADDR_TERM_COUNT, {27'd0, settings[s]});
            for (int n = 0; n < 200; n++)
            begin
                int mode;
                no_gaps = (s == 5 && n >= 120);
                mode = $urandom_range(0, 9);
                for (int k = 0; k < 6; k++)
                    tw[k] = rand_q(mode < 2 ? 0 : (mode < 6 ? 1 : (mode < 9 ? 2 : 3)));
                send_twist(tw, 0, none);
            end
            start = 1'b0;
        end

        drain();
        if (errors == 0)
            $display("se3_exp_series verification clean");
        else
            $display("se3_exp_series verification failed");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/se3_pkg.sv
rtl/core/se3_cell.sv
rtl/core/se3_exp_series.sv
verif/se3_exp_series_tb.sv
